### src/skws_pkg.sv
// Shared constants for the scalar Kalman filter with window statistics.
// No dependencies; imported by the top level.
`default_nettype none

package skws_pkg;

    localparam int DATA_W         = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int WINDOW_MAX_DEF = 1024;

    // configuration register indexes
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_PROCESS_NOISE = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MEASURE_NOISE = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_VALID_LOW     = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_VALID_HIGH    = 2'd3;

    // register reset values
    localparam logic [DATA_W-1:0] PROCESS_NOISE_RST = 32'd65;
    localparam logic [DATA_W-1:0] MEASURE_NOISE_RST = 32'd65536;
    localparam logic [DATA_W-1:0] VALID_LOW_RST     = 32'd0;
    localparam logic [DATA_W-1:0] VALID_HIGH_RST    = 32'd131072000;

    // item and result codes
    localparam logic OP_SAMPLE   = 1'b0;
    localparam logic OP_FLUSH    = 1'b1;
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_WINDOW = 1'b1;

    localparam logic [DATA_W-1:0] DATA_MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] DATA_MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};

    typedef logic [DATA_W-1:0] data_t;

endpackage

`default_nettype wire

### src/scalar_kalman_with_window_stats_top.sv
// Scalar Kalman filter for one sensor channel plus window statistics.
// Depends on skws_pkg.
//
// A sample passes these steps before the next item can be taken: the predicted
// variance is formed as the item is taken, one set-up step, the bit-serial
// restoring divider for the gain, a step that loads the gain, the bit-serial
// shift-and-add multipliers (estimate step and variance update run side by
// side), and a last step that updates the state and loads the result register
// once no earlier result still waits on out_ready. A flush runs the 32 quotient
// bits of the average through the same divider, or skips the divider on an
// empty window. The result register lets the next item be taken while a
// finished result still waits on out_ready. Configuration writes are taken at
// any time and must only be issued while the block idles.
`default_nettype none

module scalar_kalman_with_window_stats_top
    import skws_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 op,
    input  wire logic signed [31:0]   raw_sample,

    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      kind,
    output logic signed [31:0]        estimate,
    output logic signed [31:0]        window_average,
    output logic signed [31:0]        window_maximum,
    output logic signed [31:0]        window_minimum,
    output logic                      window_valid,

    input  wire logic                 cfg_write,
    input  wire logic [REG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_data
);

    localparam int KW     = FRAC_BITS + 1;
    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W  = DATA_W + $clog2(WINDOW_MAX);
    localparam int DIV_W  = DATA_W + 1;
    localparam int ITER_W = $clog2(DATA_W + 1);

    localparam logic [DATA_W-1:0] VAR_ONE  = {{(DATA_W-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic [KW-1:0]     K_ONE    = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(WINDOW_MAX);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_GAIN = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    // configuration
    data_t q_noise_reg, r_noise_reg, valid_low_reg, valid_high_reg;

    // filter and window state
    data_t             est_reg;
    data_t             var_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  cnt_reg;
    data_t             max_reg, min_reg, last_reg;

    // control
    logic [2:0]        state_reg, state_next;
    logic [ITER_W-1:0] iter_reg;
    logic              out_valid_reg;

    // datapath
    logic              op_reg;
    data_t             raw_reg;
    data_t             p_reg;
    data_t             mag_reg;
    logic              neg_reg;
    logic              dzero_reg;
    logic [DIV_W-1:0]  div_rem_reg, div_d_reg;
    data_t             div_sh_reg, div_q_reg;
    logic [KW-1:0]     mk_reg, nk_reg;
    logic [DIV_W-1:0]  acc_a_reg, acc_b_reg;

    // output register
    logic              kind_reg, wvalid_reg;
    data_t             est_out_reg, avg_out_reg, max_out_reg, min_out_reg;

    logic [DIV_W-1:0]  p_sum, d_sum, diff, diff_mag;
    data_t             p_sat;
    logic [SUM_W-1:0]  sum_mag;
    logic [DIV_W:0]    rem_shift, rem_sub;
    logic              div_ge;
    logic [DIV_W-1:0]  rem_new;
    logic [DIV_W-1:0]  add_a, add_b;
    logic [KW-1:0]     k_val;
    data_t             est_new, avg_val;
    logic              fin_go, last_iter;

    assign in_ready = (state_reg == ST_IDLE);
    assign fin_go   = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);
    assign last_iter = (iter_reg == ITER_W'(1));

    always_comb
    begin
        p_sum    = {1'b0, var_reg} + {1'b0, q_noise_reg};
        p_sat    = p_sum[DATA_W] ? '1 : p_sum[DATA_W-1:0];
        d_sum    = {1'b0, p_reg} + {1'b0, r_noise_reg};
        diff     = {raw_reg[DATA_W-1], raw_reg} - {est_reg[DATA_W-1], est_reg};
        diff_mag = diff[DATA_W] ? (~diff + 1'b1) : diff;
        sum_mag  = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;

        // one restoring quotient bit per cycle
        rem_shift = {div_rem_reg, div_sh_reg[DATA_W-1]};
        rem_sub   = rem_shift - {1'b0, div_d_reg};
        div_ge    = (rem_shift >= {1'b0, div_d_reg});
        rem_new   = div_ge ? rem_sub[DIV_W-1:0] : rem_shift[DIV_W-1:0];

        // one multiplier bit per cycle, low product bits drop off
        add_a = acc_a_reg + {1'b0, (mk_reg[0] ? mag_reg : '0)};
        add_b = acc_b_reg + {1'b0, (nk_reg[0] ? p_reg : '0)};

        k_val   = dzero_reg ? '0 : div_q_reg[KW-1:0];
        est_new = neg_reg ? (est_reg - acc_a_reg[DATA_W-1:0])
                          : (est_reg + acc_a_reg[DATA_W-1:0]);
        avg_val = neg_reg ? (~div_q_reg + 1'b1) : div_q_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_PREP;
            ST_PREP:
                if (op_reg == OP_FLUSH && cnt_reg == '0)
                    state_next = ST_FIN;
                else
                    state_next = ST_DIV;
            ST_DIV:
                if (last_iter)
                    state_next = (op_reg == OP_FLUSH) ? ST_FIN : ST_GAIN;
            ST_GAIN:
                state_next = ST_MUL;
            ST_MUL:
                if (last_iter)
                    state_next = ST_FIN;
            ST_FIN:
                if (fin_go)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            iter_reg       <= '0;
            out_valid_reg  <= 1'b0;
            q_noise_reg    <= PROCESS_NOISE_RST;
            r_noise_reg    <= MEASURE_NOISE_RST;
            valid_low_reg  <= VALID_LOW_RST;
            valid_high_reg <= VALID_HIGH_RST;
            est_reg        <= '0;
            var_reg        <= VAR_ONE;
            sum_reg        <= '0;
            cnt_reg        <= '0;
            max_reg        <= DATA_MOST_NEG;
            min_reg        <= DATA_MOST_POS;
            last_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_PROCESS_NOISE: q_noise_reg    <= cfg_data;
                    REG_MEASURE_NOISE: r_noise_reg    <= cfg_data;
                    REG_VALID_LOW:     valid_low_reg  <= cfg_data;
                    REG_VALID_HIGH:    valid_high_reg <= cfg_data;
                endcase
            end

            if (fin_go)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            if (state_reg == ST_PREP)
                iter_reg <= (op_reg == OP_FLUSH) ? ITER_W'(DATA_W) : ITER_W'(KW);
            else if (state_reg == ST_GAIN)
                iter_reg <= ITER_W'(KW);
            else if (state_reg == ST_DIV || state_reg == ST_MUL)
                iter_reg <= iter_reg - 1'b1;

            if (fin_go)
            begin
                if (op_reg == OP_SAMPLE)
                begin
                    est_reg  <= est_new;
                    var_reg  <= acc_b_reg[DATA_W-1:0];
                    if (cnt_reg < CNT_FULL)
                    begin
                        sum_reg <= sum_reg + {{(SUM_W-DATA_W){est_new[DATA_W-1]}}, est_new};
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if ($signed(est_new) > $signed(max_reg))
                        max_reg <= est_new;
                    if ($signed(est_new) < $signed(min_reg))
                        min_reg <= est_new;
                    last_reg <= est_new;
                end
                else
                begin
                    sum_reg  <= '0;
                    cnt_reg  <= '0;
                    max_reg  <= DATA_MOST_NEG;
                    min_reg  <= DATA_MOST_POS;
                    last_reg <= '0;
                end
            end
        end
    end

    // datapath and result payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg  <= op;
            raw_reg <= raw_sample;
            p_reg   <= p_sat;
        end

        unique case (state_reg)
            ST_PREP:
            begin
                div_q_reg <= '0;
                if (op_reg == OP_SAMPLE)
                begin
                    // dividend is P << FRAC_BITS, quotient is at most one
                    div_rem_reg <= {2'b00, p_reg[DATA_W-1:1]};
                    div_sh_reg  <= {p_reg[0], {(DATA_W-1){1'b0}}};
                    div_d_reg   <= d_sum;
                    dzero_reg   <= (d_sum == '0);
                    mag_reg     <= diff_mag[DATA_W-1:0];
                    neg_reg     <= diff[DATA_W];
                end
                else
                begin
                    // the average fits 32 bits, so the high part starts below count
                    div_rem_reg <= DIV_W'(sum_mag >> DATA_W);
                    div_sh_reg  <= sum_mag[DATA_W-1:0];
                    div_d_reg   <= DIV_W'(cnt_reg);
                    dzero_reg   <= 1'b0;
                    neg_reg     <= sum_reg[SUM_W-1];
                end
            end
            ST_DIV:
            begin
                div_rem_reg <= rem_new;
                div_sh_reg  <= {div_sh_reg[DATA_W-2:0], 1'b0};
                div_q_reg   <= {div_q_reg[DATA_W-2:0], div_ge};
            end
            ST_GAIN:
            begin
                mk_reg    <= k_val;
                nk_reg    <= K_ONE - k_val;
                acc_a_reg <= '0;
                acc_b_reg <= '0;
            end
            ST_MUL:
            begin
                mk_reg    <= mk_reg >> 1;
                nk_reg    <= nk_reg >> 1;
                acc_a_reg <= last_iter ? add_a : (add_a >> 1);
                acc_b_reg <= last_iter ? add_b : (add_b >> 1);
            end
            default:
            begin
            end
        endcase

        if (fin_go)
        begin
            if (op_reg == OP_SAMPLE)
            begin
                kind_reg    <= KIND_SAMPLE;
                est_out_reg <= est_new;
                avg_out_reg <= '0;
                max_out_reg <= '0;
                min_out_reg <= '0;
                wvalid_reg  <= 1'b0;
            end
            else
            begin
                kind_reg    <= KIND_WINDOW;
                est_out_reg <= est_reg;
                avg_out_reg <= (cnt_reg == '0) ? '0 : avg_val;
                max_out_reg <= (cnt_reg == '0) ? '0 : max_reg;
                min_out_reg <= (cnt_reg == '0) ? '0 : min_reg;
                wvalid_reg  <= ($signed(last_reg) > $signed(valid_low_reg))
                            && ($signed(last_reg) < $signed(valid_high_reg));
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign estimate       = est_out_reg;
    assign window_average = avg_out_reg;
    assign window_maximum = max_out_reg;
    assign window_minimum = min_out_reg;
    assign window_valid   = wvalid_reg;

    // divider remainder stays below the divisor
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && div_d_reg != '0) |-> (div_rem_reg < div_d_reg))
        else $error("divider remainder not below divisor");

    // gain never exceeds one
    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GAIN && !dzero_reg) |-> (div_q_reg <= DATA_W'(K_ONE)))
        else $error("gain above one");

    // updated variance never exceeds the predicted one
    a_var_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && op_reg == OP_SAMPLE) |-> (acc_b_reg <= {1'b0, p_reg}))
        else $error("variance grew in update");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL)
        else $error("window count beyond limit");

    // each finished item leaves exactly one result and returns to idle
    a_fin_result: assert property (@(posedge clk) disable iff (!rst_n)
        fin_go |=> (state_reg == ST_IDLE && out_valid_reg))
        else $error("result not posted after finish");

endmodule

`default_nettype wire
